@@ rtl/gamepad_pin_encoder_shift_lock_unit_assert.svh @@
// Assertion macros used by the checker file of the shift-lock pin encoder.
// Depends on nothing; each use expands to one labeled concurrent assertion.
`ifndef GAMEPAD_PIN_ENCODER_SHIFT_LOCK_UNIT_ASSERT_SVH
`define GAMEPAD_PIN_ENCODER_SHIFT_LOCK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPSL_ASSERT_IMP(lbl, clk, rstn, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GPSL_ASSERT_NXT(lbl, clk, rstn, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |=> (con)) \
    else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define GPSL_ASSERT_NXT_ALWAYS(lbl, clk, ant, con, msg) \
  lbl: assert property (@(posedge clk) (ant) |=> (con)) \
    else $error(msg);

`endif

@@ rtl/gpsl_pkg.sv @@
// Package of the shift-lock pin encoder: transaction types, codes and the
// digital hat encoding. Depends on nothing.
package gpsl_pkg;

  typedef struct packed {
    logic [7:0] port_b;
    logic [7:0] port_c;
    logic [7:0] port_d;
  } gpsl_in_t;

  typedef struct packed {
    logic [3:0]  hat_direction;
    logic [7:0]  stick_x;
    logic [7:0]  stick_y;
    logic [12:0] button_bits;
    logic        shift_active;
  } gpsl_out_t;

  localparam int unsigned CFG_DATA_W = 6;

  typedef enum logic [0:0] {
    CFG_WINDOW_MIN = 1'b0,
    CFG_WINDOW_MAX = 1'b1
  } gpsl_cfg_idx_t;

  localparam logic [CFG_DATA_W-1:0] WINDOW_MIN_RST = 6'd1;
  localparam logic [CFG_DATA_W-1:0] WINDOW_MAX_RST = 6'd50;
  localparam logic [CFG_DATA_W-1:0] GAP_TOP        = 6'd63;

  localparam logic [7:0] AXIS_LOW    = 8'h00;
  localparam logic [7:0] AXIS_CENTER = 8'h80;
  localparam logic [7:0] AXIS_HIGH   = 8'hff;

  localparam logic [3:0] HAT_UP         = 4'd0;
  localparam logic [3:0] HAT_UP_RIGHT   = 4'd1;
  localparam logic [3:0] HAT_RIGHT      = 4'd2;
  localparam logic [3:0] HAT_DOWN_RIGHT = 4'd3;
  localparam logic [3:0] HAT_DOWN       = 4'd4;
  localparam logic [3:0] HAT_DOWN_LEFT  = 4'd5;
  localparam logic [3:0] HAT_LEFT       = 4'd6;
  localparam logic [3:0] HAT_UP_LEFT    = 4'd7;
  localparam logic [3:0] HAT_CENTER     = 4'd8;

  // Down overrides up; left wins on the diagonals, right when alone.
  function automatic logic [3:0] digital_hat(input logic up, input logic down,
                                             input logic left, input logic right);
    logic [3:0] hat;
    hat = HAT_CENTER;
    if (left) hat = HAT_LEFT;
    if (right) hat = HAT_RIGHT;
    if (up) hat = left ? HAT_UP_LEFT : (right ? HAT_UP_RIGHT : HAT_UP);
    if (down) hat = left ? HAT_DOWN_LEFT : (right ? HAT_DOWN_RIGHT : HAT_DOWN);
    return hat;
  endfunction

endpackage

@@ rtl/gamepad_pin_encoder_shift_lock_unit.sv @@
// Top level of the shift-lock pin encoder: input register, shift-lock state
// and report logic, result register. Depends on gpsl_pkg.
//
//   channel | direction | handshake                 | payload
//   in_     | input     | in_valid / in_stall       | gpsl_in_t  in_data
//   out_    | output    | out_valid / out_stall     | gpsl_out_t out_data
//   cfg_    | input     | cfg_we (no back-pressure) | cfg_index, cfg_data
//
// One transaction per cycle is accepted while the result is not stalled; its result is valid
// once the result register takes the input register's report.
// While a result is stalled, the input register takes one more transaction, then stalls.
// Reset is synchronous and active low; it restores the window registers and
// the shift-lock state, and empties both registers.
module gamepad_pin_encoder_shift_lock_unit
  import gpsl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  gpsl_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output gpsl_out_t             out_data,
  input  logic                  cfg_we,
  input  gpsl_cfg_idx_t         cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0] win_min_r, win_max_r;
  logic                  in_vld_r, in_vld_nxt;
  gpsl_in_t              in_r;
  logic                  out_vld_r, out_vld_nxt;
  gpsl_out_t             out_r, out_nxt;

  logic                  was_pressed_r, lock_r, lock_nxt;
  logic [CFG_DATA_W-1:0] gap_r, gap_nxt, gap_cur;
  logic [7:0]            held_x_r, held_y_r, held_x_nxt, held_y_nxt;

  logic advance, take, process;
  logic pressed, press_edge, up, down, left, right, shift;

  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !advance;
  assign take     = in_valid && !in_stall;
  assign process  = in_vld_r && advance;

  assign pressed    = !in_r.port_d[7];
  assign up         = !in_r.port_c[2];
  assign down       = !in_r.port_d[0];
  assign left       = !in_r.port_d[1];
  assign right      = !in_r.port_d[2];
  assign press_edge = pressed && !was_pressed_r;

  always_comb begin
    lock_nxt = lock_r;
    gap_cur  = gap_r;
    if (press_edge) begin
      if ((gap_r > win_min_r) && (gap_r < win_max_r)) lock_nxt = !lock_r;
      gap_cur = '0;
    end
    gap_nxt = gap_cur;
    if ((gap_cur <= win_max_r) && (gap_cur != GAP_TOP)) gap_nxt = gap_cur + 6'd1;
    shift = pressed || lock_nxt;

    held_x_nxt = held_x_r;
    held_y_nxt = held_y_r;
    out_nxt.hat_direction = HAT_CENTER;
    if (shift) begin
      held_y_nxt = down ? AXIS_HIGH : (up ? AXIS_LOW : AXIS_CENTER);
      held_x_nxt = right ? AXIS_HIGH : (left ? AXIS_LOW : AXIS_CENTER);
    end else begin
      out_nxt.hat_direction = digital_hat(up, down, left, right);
    end
    out_nxt.stick_x      = held_x_nxt;
    out_nxt.stick_y      = held_y_nxt;
    out_nxt.button_bits  = ~{in_r.port_c[5], in_r.port_b[7], in_r.port_b[6],
                             in_r.port_c[6], in_r.port_c[7], in_r.port_b[5:0],
                             in_r.port_d[4], in_r.port_d[3]};
    out_nxt.shift_active = shift;
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (take) in_vld_nxt = 1'b1;
    else if (advance) in_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (process) out_vld_nxt = 1'b1;
    else if (advance) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_min_r     <= WINDOW_MIN_RST;
      win_max_r     <= WINDOW_MAX_RST;
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      was_pressed_r <= 1'b0;
      lock_r        <= 1'b0;
      gap_r         <= '0;
      held_x_r      <= AXIS_CENTER;
      held_y_r      <= AXIS_CENTER;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_MIN: win_min_r <= cfg_data;
          CFG_WINDOW_MAX: win_max_r <= cfg_data;
          default: ;
        endcase
      end
      if (process) begin
        was_pressed_r <= pressed;
        lock_r        <= lock_nxt;
        gap_r         <= gap_nxt;
        held_x_r      <= held_x_nxt;
        held_y_r      <= held_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) in_r <= in_data;
    if (process) out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

@@ rtl/gpsl_checker.sv @@
// Port-level checker of the shift-lock pin encoder and its bind statement.
// Depends on gpsl_pkg and gamepad_pin_encoder_shift_lock_unit_assert.svh.
`include "gamepad_pin_encoder_shift_lock_unit_assert.svh"

module gpsl_checker
  import gpsl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input gpsl_out_t out_data
);

  `GPSL_ASSERT_NXT_ALWAYS(a_reset_empties, clk, !rst_n, !out_valid, "result valid after reset")
  `GPSL_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `GPSL_ASSERT_IMP(a_no_idle_stall, clk, rst_n, !out_valid, !in_stall, "input stalled with empty output")
  `GPSL_ASSERT_IMP(a_analog_hat, clk, rst_n, out_valid && out_data.shift_active, out_data.hat_direction == HAT_CENTER, "hat not centered in analog mode")

endmodule

bind gamepad_pin_encoder_shift_lock_unit gpsl_checker u_gpsl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
